// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define VLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define VLMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/vlms_pkg.sv -----
`timescale 1ns / 1ps
package vlms_pkg;

  localparam int SMP_W  = 16;
  localparam int WGT_W  = 24;
  localparam int ERR_W  = 17;
  localparam int STEP_W = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DECAY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN = 8'd3;

  localparam logic [STEP_W-1:0] RST_STEP_MIN   = 16'd16;
  localparam logic [STEP_W-1:0] RST_STEP_MAX   = 16'd6554;
  localparam logic [STEP_W-1:0] RST_STEP_DECAY = 16'd64880;
  localparam logic [STEP_W-1:0] RST_ERROR_GAIN = 16'd66;

  typedef struct packed {
    logic load;
    logic mac_rd;
    logic calc_ye;
    logic calc_sq;
    logic calc_mul;
    logic calc_step;
    logic calc_me;
    logic upd_rd;
    logic upd_done;
    logic out_load;
  } vlms_cmd_t;

endpackage

// ----- hw/rtl/vlms_ram.sv -----
`timescale 1ns / 1ps
module vlms_ram #(
  parameter int W = 16,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/vlms_ctrl.sv -----
`timescale 1ns / 1ps
module vlms_ctrl import vlms_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output vlms_cmd_t               cmd,
  output logic [$clog2(TAPS)-1:0] idx
);
  localparam int IW = $clog2(TAPS);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_MDRAIN, S_YE, S_SQ, S_MUL, S_STEP, S_ME, S_UPD, S_UDRAIN, S_OUT
  } state_t;

  state_t        state_r;
  logic [IW-1:0] cnt_r;
  logic          out_valid_r;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign idx       = cnt_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.mac_rd    = (state_r == S_MAC);
    cmd.calc_ye   = (state_r == S_YE);
    cmd.calc_sq   = (state_r == S_SQ);
    cmd.calc_mul  = (state_r == S_MUL);
    cmd.calc_step = (state_r == S_STEP);
    cmd.calc_me   = (state_r == S_ME);
    cmd.upd_rd    = (state_r == S_UPD);
    cmd.upd_done  = (state_r == S_UDRAIN) && (cnt_r == IW'(1));
    cmd.out_load  = (state_r == S_OUT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !cmd.out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid) begin
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (cnt_r == IW'(TAPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_MDRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MDRAIN: begin
          if (cnt_r == IW'(1)) begin
            cnt_r   <= '0;
            state_r <= S_YE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_YE:   state_r <= S_SQ;
        S_SQ:   state_r <= S_MUL;
        S_MUL:  state_r <= S_STEP;
        S_STEP: state_r <= S_ME;
        S_ME: begin
          cnt_r   <= '0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (cnt_r == IW'(TAPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_UDRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_UDRAIN: begin
          if (cnt_r == IW'(1)) begin
            cnt_r   <= '0;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/vlms_dp.sv -----
`timescale 1ns / 1ps
module vlms_dp import vlms_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vlms_cmd_t                cmd,
  input  logic [$clog2(TAPS)-1:0]  idx,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [STEP_W-1:0]        cfg_data,
  input  logic signed [SMP_W-1:0]  input_sample,
  input  logic signed [SMP_W-1:0]  desired_sample,
  output logic signed [SMP_W-1:0]  filter_output,
  output logic signed [ERR_W-1:0]  error_value,
  output logic [STEP_W-1:0]        current_step
);
  localparam int IW    = $clog2(TAPS);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int PW    = WGT_W + SMP_W;
  localparam int ACC_W = PW + IW;
  localparam int ME_W  = 2 * ERR_W;
  localparam int UP_W  = ME_W + SMP_W;
  localparam int DL_W  = UP_W + 1 - 24;

  logic [STEP_W-1:0] step_min_r, step_max_r, step_decay_r, error_gain_r, step_r;
  logic [IW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     fill_r;
  logic              wvalid_r;
  logic signed [SMP_W-1:0] d_r;

  logic [IW-1:0]      tap_raddr;
  logic [IW:0]        tap_sum;
  logic [SMP_W-1:0]   tap_rd;
  logic [WGT_W-1:0]   wgt_rd;
  logic               wgt_we;
  logic [WGT_W-1:0]   wgt_wdata;

  logic               mac_v1_r, mac_v2_r, up_v1_r, up_v2_r, tvalid1_r;
  logic [IW-1:0]      idx1_r, idx2_r;
  logic signed [SMP_W-1:0] t_eff;
  logic signed [WGT_W-1:0] w_eff;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [ACC_W:0]          acc_rnd;
  logic signed [ACC_W-22:0]       y_wide;
  logic signed [SMP_W-1:0]        y_sat, y_r;
  logic signed [ERR_W-1:0]        e_r;
  logic signed [ME_W-1:0]         e_sq;
  logic [31:0]                    e2_r;
  logic [47:0]                    ge_r;
  logic [31:0]                    ad_r;
  logic [48:0]                    ssum;
  logic [18:0]                    mu;
  logic [STEP_W-1:0]              mu_hi, mu_c;
  logic signed [ME_W-1:0]         me_r;
  logic signed [UP_W-1:0]         uprod_r;
  logic signed [WGT_W-1:0]        wold_r;
  logic signed [UP_W:0]           up_rnd;
  logic signed [DL_W-1:0]         delta;
  logic signed [DL_W:0]           wsum;

  assign head_nxt = (head_r == '0) ? IW'(TAPS - 1) : head_r - 1'b1;
  assign tap_sum  = {1'b0, head_r} + {1'b0, idx};
  assign tap_raddr = (tap_sum >= (IW + 1)'(TAPS)) ? IW'(tap_sum - (IW + 1)'(TAPS))
                                                  : tap_sum[IW-1:0];

  vlms_ram #(.W(SMP_W), .D(TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (head_nxt),
    .wdata (input_sample),
    .raddr (tap_raddr),
    .rdata (tap_rd)
  );

  vlms_ram #(.W(WGT_W), .D(TAPS)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (idx2_r),
    .wdata (wgt_wdata),
    .raddr (idx),
    .rdata (wgt_rd)
  );

  assign t_eff = tvalid1_r ? $signed(tap_rd) : '0;
  assign w_eff = wvalid_r ? $signed(wgt_rd) : '0;

  assign acc_rnd = {acc_r[ACC_W-1], acc_r} + (ACC_W + 1)'(1 << 21);
  assign y_wide  = acc_rnd[ACC_W:22];
  always_comb begin
    if (y_wide > (ACC_W - 21)'(32767)) begin
      y_sat = 16'sd32767;
    end else if (y_wide < -(ACC_W - 21)'(32768)) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = y_wide[SMP_W-1:0];
    end
  end

  assign e_sq  = e_r * e_r;
  assign ssum  = {3'b0, ad_r, 14'b0} + {1'b0, ge_r} + 49'(1 << 29);
  assign mu    = ssum[48:30];
  assign mu_hi = (mu > {3'b0, step_max_r}) ? step_max_r : mu[STEP_W-1:0];
  assign mu_c  = (mu_hi < step_min_r) ? step_min_r : mu_hi;

  assign up_rnd = {uprod_r[UP_W-1], uprod_r} + (UP_W + 1)'(1 << 23);
  assign delta  = DL_W'(up_rnd >>> 24);
  assign wsum   = DL_W'(wold_r) + delta;
  assign wgt_we = up_v2_r;
  always_comb begin
    if (wsum > (DL_W + 1)'(8388607)) begin
      wgt_wdata = 24'h7FFFFF;
    end else if (wsum < -(DL_W + 1)'(8388608)) begin
      wgt_wdata = 24'h800000;
    end else begin
      wgt_wdata = wsum[WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_min_r   <= RST_STEP_MIN;
      step_max_r   <= RST_STEP_MAX;
      step_decay_r <= RST_STEP_DECAY;
      error_gain_r <= RST_ERROR_GAIN;
      step_r       <= RST_STEP_MIN;
      head_r       <= '0;
      fill_r       <= '0;
      wvalid_r     <= 1'b0;
      mac_v1_r     <= 1'b0;
      mac_v2_r     <= 1'b0;
      up_v1_r      <= 1'b0;
      up_v2_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_MIN:   step_min_r   <= cfg_data;
          REG_STEP_MAX:   step_max_r   <= cfg_data;
          REG_STEP_DECAY: step_decay_r <= cfg_data;
          REG_ERROR_GAIN: error_gain_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        head_r <= head_nxt;
        if (fill_r != FW'(TAPS)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.calc_step) begin
        step_r <= mu_c;
      end
      if (cmd.upd_done) begin
        wvalid_r <= 1'b1;
      end
      mac_v1_r <= cmd.mac_rd;
      mac_v2_r <= mac_v1_r;
      up_v1_r  <= cmd.upd_rd;
      up_v2_r  <= up_v1_r;
    end
  end

  always_ff @(posedge clk) begin
    tvalid1_r <= (FW'(idx) < fill_r);
    idx1_r    <= idx;
    idx2_r    <= idx1_r;
    prod_r    <= w_eff * t_eff;
    uprod_r   <= me_r * t_eff;
    wold_r    <= w_eff;
    if (cmd.load) begin
      d_r   <= desired_sample;
      acc_r <= '0;
    end else if (mac_v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.calc_ye) begin
      y_r <= y_sat;
      e_r <= ERR_W'(d_r) - ERR_W'(y_sat);
    end
    if (cmd.calc_sq) begin
      e2_r <= e_sq[31:0];
    end
    if (cmd.calc_mul) begin
      ge_r <= error_gain_r * e2_r;
      ad_r <= step_decay_r * step_r;
    end
    if (cmd.calc_me) begin
      me_r <= e_r * $signed({1'b0, step_r});
    end
    if (cmd.out_load) begin
      filter_output <= y_r;
      error_value   <= e_r;
      current_step  <= step_r;
    end
  end
endmodule

// ----- hw/rtl/vss_lms_adaptive_fir.sv -----
// Each sample gets one pass over the tap and weight memories for the output and a
//   second for the update; the next sample is taken only after the result is
//   registered, which waits for a free output slot.
// Reset (rst_n low, synchronous): control and config registers to defaults, step to step_min,
//   tap line and weights read as zero until written.
`timescale 1ns / 1ps
module vss_lms_adaptive_fir import vlms_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_input_sample,
  input  logic signed [SMP_W-1:0] in_desired_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_filter_output,
  output logic signed [ERR_W-1:0] out_error_value,
  output logic [STEP_W-1:0]       out_current_step,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [STEP_W-1:0]       cfg_data
);
  vlms_cmd_t               cmd;
  logic [$clog2(TAPS)-1:0] idx;

  assign cfg_ready = 1'b1;

  vlms_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .idx       (idx)
  );

  vlms_dp #(.TAPS(TAPS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .idx            (idx),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .input_sample   (in_input_sample),
    .desired_sample (in_desired_sample),
    .filter_output  (out_filter_output),
    .error_value    (out_error_value),
    .current_step   (out_current_step)
  );
endmodule

// ----- hw/rtl/vlms_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vlms_checker import vlms_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SMP_W-1:0] out_filter_output,
  input logic signed [ERR_W-1:0] out_error_value,
  input logic [STEP_W-1:0]       out_current_step
);
  logic [SMP_W+ERR_W+STEP_W-1:0] out_bits;

  assign out_bits = {out_filter_output, out_error_value, out_current_step};

  `VLMS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result item dropped")
  `VLMS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_bits), "item changed")
  `VLMS_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")
  `VLMS_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "item taken while busy")
endmodule

bind vss_lms_adaptive_fir vlms_checker u_vlms_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_filter_output (out_filter_output),
  .out_error_value   (out_error_value),
  .out_current_step  (out_current_step)
);
